>>> hdl/ft12_pkg.sv
// Package with the shared types and constants of the FT1.2 link frame checker.
`timescale 1ns / 1ps

package ft12_pkg;

    localparam logic [7:0] START_FIXED = 8'h10;
    localparam logic [7:0] START_VAR   = 8'h68;
    localparam logic [7:0] END_BYTE    = 8'h16;

    typedef enum logic [1:0] {
        KIND_REJECTED = 2'd0,
        KIND_FIXED    = 2'd1,
        KIND_VARIABLE = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_FRAMING   = 3'd2,
        ST_CHECKSUM  = 3'd3,
        ST_LENGTH    = 3'd4
    } t_status;

    // Per-frame state collected from the words seen so far.
    typedef struct packed {
        logic [8:0]  idx;
        logic [7:0]  start_code;
        logic [7:0]  declared_length;
        logic [7:0]  held_control;
        logic [15:0] held_address;
        logic [7:0]  running_sum;
        logic [7:0]  previous_byte;
    } t_frame_state;

    typedef struct packed {
        t_kind       kind;
        t_status     status;
        logic [7:0]  control_byte;
        logic        direction_bit;
        logic        primary_bit;
        logic        frame_count_bit;
        logic        count_valid_bit;
        logic        access_demand_bit;
        logic        flow_control_bit;
        logic [3:0]  function_code;
        logic        function_valid;
        logic [15:0] link_address;
    } t_result;

endpackage

>>> hdl/ft12_if.sv
// Channel interfaces for received frame words and for frame verdicts.
`timescale 1ns / 1ps

interface ft12_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;

    modport source (output valid, output frame_byte, output frame_end, input ready);
    modport sink (input valid, input frame_byte, input frame_end, output ready);
endinterface

interface ft12_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  frame_kind;
    logic [2:0]  status;
    logic [7:0]  control_byte;
    logic        direction_bit;
    logic        primary_bit;
    logic        frame_count_bit;
    logic        count_valid_bit;
    logic        access_demand_bit;
    logic        flow_control_bit;
    logic [3:0]  function_code;
    logic        function_valid;
    logic [15:0] link_address;

    modport source (
        output valid, output frame_kind, output status, output control_byte,
        output direction_bit, output primary_bit, output frame_count_bit,
        output count_valid_bit, output access_demand_bit, output flow_control_bit,
        output function_code, output function_valid, output link_address,
        input ready
    );
    modport sink (
        input valid, input frame_kind, input status, input control_byte,
        input direction_bit, input primary_bit, input frame_count_bit,
        input count_valid_bit, input access_demand_bit, input flow_control_bit,
        input function_code, input function_valid, input link_address,
        output ready
    );
endinterface

>>> hdl/ft12_track.sv
// Frame state tracker: byte counter, captured fields and running checksum.
`timescale 1ns / 1ps

module ft12_track
    import ft12_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_step,
    input  logic [7:0]   i_byte,
    input  logic         i_end,
    input  logic [1:0]   i_addr_len,
    output t_frame_state o_state
);

    t_frame_state r_st;
    t_frame_state n_st;
    logic [8:0]   w_ctrl_end;

    // Index of the last address word in a fixed frame.
    assign w_ctrl_end = 9'd1 + {7'b0, i_addr_len};

    always_comb begin
        n_st = r_st;
        if (i_end) begin
            n_st = '0;
        end else begin
            if (r_st.idx == 9'd0) begin
                n_st.start_code = i_byte;
            end else begin
                if (r_st.idx == 9'd1) begin
                    n_st.declared_length = i_byte;
                end
                if (r_st.start_code == START_FIXED) begin
                    if (r_st.idx == 9'd1) begin
                        n_st.held_control = i_byte;
                    end else if (r_st.idx == 9'd2 && i_addr_len >= 2'd1) begin
                        n_st.held_address[7:0] = i_byte;
                    end else if (r_st.idx == 9'd3 && i_addr_len >= 2'd2) begin
                        n_st.held_address[15:8] = i_byte;
                    end
                    if (r_st.idx <= w_ctrl_end) begin
                        n_st.running_sum = r_st.running_sum + i_byte;
                    end else if (r_st.idx == w_ctrl_end + 9'd1) begin
                        n_st.running_sum = r_st.running_sum - i_byte;
                    end
                end else if (r_st.start_code == START_VAR) begin
                    if (r_st.idx == 9'd4) begin
                        n_st.held_control = i_byte;
                    end else if (r_st.idx == 9'd5 && i_addr_len >= 2'd1) begin
                        n_st.held_address[7:0] = i_byte;
                    end else if (r_st.idx == 9'd6 && i_addr_len >= 2'd2) begin
                        n_st.held_address[15:8] = i_byte;
                    end
                    if (r_st.idx >= 9'd4) begin
                        n_st.running_sum = r_st.running_sum + i_byte;
                    end
                end
            end
            n_st.previous_byte = i_byte;
            // The counter saturates so that a runaway frame does not wrap back to the start index.
            if (r_st.idx != 9'd511) begin
                n_st.idx = r_st.idx + 9'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (i_step) begin
            r_st <= n_st;
        end
    end

    assign o_state = r_st;

endmodule

>>> hdl/ft12_verdict.sv
// Verdict logic and result register: frame checks and control byte decode.
`timescale 1ns / 1ps

module ft12_verdict
    import ft12_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  logic [7:0]    i_byte,
    input  t_frame_state  i_state,
    input  logic [1:0]    i_addr_len,
    output logic          o_free,
    ft12_res_if.source    o_res
);

    logic [9:0] w_size;
    logic [9:0] w_fixed_size;
    logic [7:0] w_var_sum;
    logic [7:0] w_c;
    logic [3:0] w_fc;
    t_result    w_res;
    t_result    r_res;
    logic       r_valid;

    assign w_size       = {1'b0, i_state.idx} + 10'd1;
    assign w_fixed_size = 10'd4 + {8'b0, i_addr_len};
    // The accumulator already holds the checksum word, so it is taken back out.
    assign w_var_sum    = (w_size >= 10'd6) ?
                          (i_state.running_sum - i_state.previous_byte) : 8'd0;
    assign w_c          = i_state.held_control;
    assign w_fc         = w_c[3:0];

    always_comb begin
        w_res        = '0;
        w_res.kind   = KIND_REJECTED;
        w_res.status = ST_OK;
        if (w_size < w_fixed_size) begin
            w_res.status = ST_SHORT;
        end else if (i_byte != END_BYTE ||
                     (i_state.start_code != START_FIXED &&
                      i_state.start_code != START_VAR)) begin
            w_res.status = ST_FRAMING;
        end else if (i_state.start_code == START_FIXED) begin
            if (i_state.running_sum != 8'd0) begin
                w_res.status = ST_CHECKSUM;
            end else if (w_size != w_fixed_size) begin
                w_res.status = ST_LENGTH;
            end else begin
                w_res.kind = KIND_FIXED;
            end
        end else begin
            if (w_var_sum != i_state.previous_byte) begin
                w_res.status = ST_CHECKSUM;
            end else if (w_size != {2'b0, i_state.declared_length} + 10'd6) begin
                w_res.status = ST_LENGTH;
            end else begin
                w_res.kind = KIND_VARIABLE;
            end
        end

        if (w_res.kind != KIND_REJECTED) begin
            w_res.control_byte      = w_c;
            w_res.direction_bit     = w_c[7];
            w_res.primary_bit       = w_c[6];
            w_res.frame_count_bit   = !w_c[7] && w_c[6] && w_c[5];
            w_res.count_valid_bit   = !w_c[7] && w_c[6] && w_c[4];
            w_res.access_demand_bit = !w_c[7] && !w_c[6] && w_c[5];
            w_res.flow_control_bit  = (w_c[7] || !w_c[6]) && w_c[4];
            w_res.function_code     = w_fc;
            w_res.function_valid    = (w_fc <= 4'd4) || (w_fc >= 4'd8 && w_fc <= 4'd11);
            w_res.link_address      = i_state.held_address;
        end
    end

    assign o_free = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= w_res;
        end
    end

    assign o_res.valid             = r_valid;
    assign o_res.frame_kind        = r_res.kind;
    assign o_res.status            = r_res.status;
    assign o_res.control_byte      = r_res.control_byte;
    assign o_res.direction_bit     = r_res.direction_bit;
    assign o_res.primary_bit       = r_res.primary_bit;
    assign o_res.frame_count_bit   = r_res.frame_count_bit;
    assign o_res.count_valid_bit   = r_res.count_valid_bit;
    assign o_res.access_demand_bit = r_res.access_demand_bit;
    assign o_res.flow_control_bit  = r_res.flow_control_bit;
    assign o_res.function_code     = r_res.function_code;
    assign o_res.function_valid    = r_res.function_valid;
    assign o_res.link_address      = r_res.link_address;

endmodule

>>> hdl/ft12_link_frame_checker.sv
// A word is registered in the input register on acceptance and processed when it moves on;
// the verdict for the last word of a frame is then held in the result register.
// Throughput: one word per cycle while no verdict waits on a stalled output.
// A verdict waiting on a stalled output holds back only the next last word of a frame.
// Reset (synchronous, active low) clears the frame state and empties both registers;
// the address byte count returns to two.
`timescale 1ns / 1ps

module ft12_link_frame_checker
    import ft12_pkg::*;
#(
    parameter int MAX_ADDR_BYTES = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    ft12_byte_if.sink   i_frame,
    ft12_res_if.source  o_verdict
);

    logic         r_in_valid;
    logic [7:0]   r_in_byte;
    logic         r_in_end;
    logic [1:0]   r_addr_bytes;
    logic [1:0]   w_addr_len;
    logic         w_go;
    logic         w_out_free;
    t_frame_state w_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr_bytes <= 2'd2;
        end else if (i_cfg_we) begin
            r_addr_bytes <= i_cfg_wdata;
        end
    end

    assign w_addr_len = (int'(r_addr_bytes) > MAX_ADDR_BYTES) ?
                        2'(MAX_ADDR_BYTES) : r_addr_bytes;

    // Ordinary words always move on; only the last word of a frame needs the result slot.
    assign w_go          = r_in_valid && (!r_in_end || w_out_free);
    assign i_frame.ready = !r_in_valid || w_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_frame.ready) begin
            r_in_valid <= i_frame.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_frame.ready && i_frame.valid) begin
            r_in_byte <= i_frame.frame_byte;
            r_in_end  <= i_frame.frame_end;
        end
    end

    ft12_track u_track (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_go),
        .i_byte     (r_in_byte),
        .i_end      (r_in_end),
        .i_addr_len (w_addr_len),
        .o_state    (w_state)
    );

    ft12_verdict u_verdict (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_go && r_in_end),
        .i_byte     (r_in_byte),
        .i_state    (w_state),
        .i_addr_len (w_addr_len),
        .o_free     (w_out_free),
        .o_res      (o_verdict)
    );

`ifndef SYNTHESIS
    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go && r_in_end |=> w_state.idx == 9'd0 && w_state.running_sum == 8'd0)
        else $error("frame state not cleared after the last word");

    a_verdict_follows_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go && r_in_end |=> o_verdict.valid)
        else $error("no verdict after the last word of a frame");

    a_ok_means_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_verdict.valid |->
            ((o_verdict.status == ST_OK) == (o_verdict.frame_kind != KIND_REJECTED)))
        else $error("status and frame kind disagree");

    a_rejected_is_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_verdict.valid && o_verdict.frame_kind == KIND_REJECTED |->
            o_verdict.control_byte == 8'd0 && o_verdict.link_address == 16'd0)
        else $error("rejected frame carries decoded fields");

    a_no_loss_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_verdict.valid && !o_verdict.ready |-> !(w_go && r_in_end))
        else $error("verdict overwritten while stalled");
`endif

endmodule
